@@ src/ps2mc_pkg.sv @@
// Shared types and constants of the PS/2 mouse packet cursor unit.
`timescale 1ns / 1ps

package ps2mc_pkg;

  // Screen size register width and reset size
  localparam int unsigned SIZE_W = 13;
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;

  // Header byte check: bits 7 and 6 low, bit 3 high
  localparam logic [7:0] FIRST_MASK  = 8'hC8;
  localparam logic [7:0] FIRST_MATCH = 8'h08;

  localparam int unsigned BUTTON_BITS = 3;

  // Position of the next byte within a packet
  localparam int unsigned IDX_W = 2;
  localparam logic [IDX_W-1:0] IDX_FIRST = 2'd0;
  localparam logic [IDX_W-1:0] IDX_THIRD = 2'd2;

  typedef enum logic {
    OP_BYTE   = 1'b0,
    OP_REINIT = 1'b1
  } op_e;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage

@@ src/ps2mc_axis.sv @@
// One cursor axis: move by a signed byte, clamp to the screen, and screen center.
`timescale 1ns / 1ps

module ps2mc_axis
  import ps2mc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter bit          NEGATE     = 1'b0
) (
  input  logic [SIZE_W-1:0]     size_i,
  input  logic [COORD_BITS-1:0] pos_i,
  input  logic [7:0]            delta_i,
  output logic [COORD_BITS-1:0] moved_o,
  output logic [COORD_BITS-1:0] center_o
);

  localparam int unsigned LW = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;
  localparam int unsigned EW = LW + 1;

  logic [LW-1:0]        size_ext;
  logic [LW-1:0]        coord_max;
  logic [LW-1:0]        limit_raw;
  logic [LW-1:0]        limit;
  logic [LW-1:0]        half;
  logic signed [EW-1:0] pos_ext;
  logic signed [EW-1:0] delta_ext;
  logic signed [EW-1:0] sum;
  logic signed [EW-1:0] limit_s;

  assign size_ext  = LW'(size_i);
  assign coord_max = LW'({COORD_BITS{1'b1}});

  // A zero size behaves as one; saturate at the largest coordinate
  assign limit_raw = (size_i == '0) ? '0 : size_ext - LW'(1);
  assign limit     = (limit_raw > coord_max) ? coord_max : limit_raw;

  assign half      = size_ext >> 1;
  assign center_o  = COORD_BITS'((half > coord_max) ? coord_max : half);

  assign pos_ext   = signed'(EW'(pos_i));
  assign delta_ext = EW'(signed'(delta_i));
  assign sum       = NEGATE ? (pos_ext - delta_ext) : (pos_ext + delta_ext);
  assign limit_s   = signed'(EW'(limit));

  always_comb begin
    if (sum[EW-1]) begin
      moved_o = '0;
    end else if (sum > limit_s) begin
      moved_o = COORD_BITS'(limit);
    end else begin
      moved_o = COORD_BITS'(sum);
    end
  end

endmodule

@@ src/ps2_mouse_packet_cursor_unit.sv @@
// Top level of the PS/2 mouse packet decoder with clamped screen cursor.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// -------   -----------------------   -------------------------------------------
// in        in_valid_i / in_ready_o   op_i, data_byte_i, from_aux_i
// out       out_valid_o / out_ready_i ptr_x_o, ptr_y_o, button_bits_o,
//                                     packet_done_o, byte_stored_o,
//                                     packets_seen_o, bytes_seen_o
// cfg       cfg_we_i (no handshake)   cfg_idx_i, cfg_data_i
//
// Each input word yields one result word on the next cycle; the decode,
// add and clamp all sit in one level of logic ahead of the state registers.
// A new word is taken every cycle while the result register is empty or
// being drained, so the sustained rate is one word per cycle.
// The cursor, counters and buttons are the result: they change only when a
// word is accepted, so a stalled result holds without an extra copy.
// Reset centers the cursor on a 640x480 screen and clears all counters.

module ps2_mouse_packet_cursor_unit
  import ps2mc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [SIZE_W-1:0]      cfg_data_i,
  // input words
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   op_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   from_aux_i,
  // result words
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_BITS-1:0]  ptr_x_o,
  output logic [COORD_BITS-1:0]  ptr_y_o,
  output logic [BUTTON_BITS-1:0] button_bits_o,
  output logic                   packet_done_o,
  output logic                   byte_stored_o,
  output logic [COUNT_BITS-1:0]  packets_seen_o,
  output logic [COUNT_BITS-1:0]  bytes_seen_o
);

  localparam int unsigned HALF_W = RESET_WIDTH / 2;
  localparam int unsigned HALF_H = RESET_HEIGHT / 2;
  localparam int unsigned CMAX   = (1 << COORD_BITS) - 1;
  localparam logic [COORD_BITS-1:0] RST_X = COORD_BITS'((HALF_W > CMAX) ? CMAX : HALF_W);
  localparam logic [COORD_BITS-1:0] RST_Y = COORD_BITS'((HALF_H > CMAX) ? CMAX : HALF_H);

  // Screen size registers
  logic [SIZE_W-1:0] width_q, height_q;

  // Packet and cursor state
  logic [7:0]             held_q [2];
  logic [7:0]             held_d [2];
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [COORD_BITS-1:0]  pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0]  pos_y_q, pos_y_d;
  logic [BUTTON_BITS-1:0] buttons_q, buttons_d;
  logic [COUNT_BITS-1:0]  pkt_cnt_q, pkt_cnt_d;
  logic [COUNT_BITS-1:0]  byte_cnt_q, byte_cnt_d;

  // Result flags
  logic out_valid_q, out_valid_d;
  logic done_q, done_d;
  logic stored_q, stored_d;

  logic                  accept;
  logic                  header_bad;
  logic [COORD_BITS-1:0] moved_x, moved_y;
  logic [COORD_BITS-1:0] center_x, center_y;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign header_bad = (idx_q == IDX_FIRST) && ((data_byte_i & FIRST_MASK) != FIRST_MATCH);

  // x adds the second byte, y subtracts the third (screen rows grow downward)
  ps2mc_axis #(
    .COORD_BITS (COORD_BITS),
    .NEGATE     (1'b0)
  ) u_axis_x (
    .size_i   (width_q),
    .pos_i    (pos_x_q),
    .delta_i  (held_q[1]),
    .moved_o  (moved_x),
    .center_o (center_x)
  );

  ps2mc_axis #(
    .COORD_BITS (COORD_BITS),
    .NEGATE     (1'b1)
  ) u_axis_y (
    .size_i   (height_q),
    .pos_i    (pos_y_q),
    .delta_i  (data_byte_i),
    .moved_o  (moved_y),
    .center_o (center_y)
  );

  // Next-state decode for one word
  always_comb begin
    held_d     = held_q;
    idx_d      = idx_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    buttons_d  = buttons_q;
    pkt_cnt_d  = pkt_cnt_q;
    byte_cnt_d = byte_cnt_q;
    done_d     = done_q;
    stored_d   = stored_q;

    if (accept) begin
      done_d   = 1'b0;
      stored_d = 1'b0;
      unique case (op_e'(op_i))
        OP_REINIT: begin
          // recenter on the current screen, clear packet progress, buttons and counters
          pos_x_d    = center_x;
          pos_y_d    = center_y;
          idx_d      = IDX_FIRST;
          buttons_d  = '0;
          pkt_cnt_d  = '0;
          byte_cnt_d = '0;
        end
        OP_BYTE: begin
          // drop anything that is not from the mouse port
          if (from_aux_i) begin
            byte_cnt_d = byte_cnt_q + COUNT_BITS'(1);
            priority if (header_bad) begin
              // drop a bad header byte; stay waiting for the first byte
            end else if (idx_q != IDX_THIRD) begin
              held_d[idx_q[0]] = data_byte_i;
              idx_d            = idx_q + IDX_W'(1);
              stored_d         = 1'b1;
            end else begin
              pos_x_d   = moved_x;
              pos_y_d   = moved_y;
              buttons_d = held_q[0][BUTTON_BITS-1:0];
              pkt_cnt_d = pkt_cnt_q + COUNT_BITS'(1);
              idx_d     = IDX_FIRST;
              stored_d  = 1'b1;
              done_d    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register fills on accept, empties when taken
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IDX_FIRST;
      pos_x_q     <= RST_X;
      pos_y_q     <= RST_Y;
      buttons_q   <= '0;
      pkt_cnt_q   <= '0;
      byte_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      stored_q    <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      buttons_q   <= buttons_d;
      pkt_cnt_q   <= pkt_cnt_d;
      byte_cnt_q  <= byte_cnt_d;
      out_valid_q <= out_valid_d;
      done_q      <= done_d;
      stored_q    <= stored_d;
    end
  end

  // Held packet bytes are always written before use
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  assign out_valid_o    = out_valid_q;
  assign ptr_x_o        = pos_x_q;
  assign ptr_y_o        = pos_y_q;
  assign button_bits_o  = buttons_q;
  assign packet_done_o  = done_q;
  assign byte_stored_o  = stored_q;
  assign packets_seen_o = pkt_cnt_q;
  assign bytes_seen_o   = byte_cnt_q;

endmodule

@@ src/ps2mc_checker.sv @@
// Port-level checks of the PS/2 mouse packet cursor unit, bound to the top level.
`timescale 1ns / 1ps

module ps2mc_checker
  import ps2mc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COUNT_BITS = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   op_i,
  input logic                   from_aux_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [COORD_BITS-1:0]  ptr_x_o,
  input logic [COORD_BITS-1:0]  ptr_y_o,
  input logic [BUTTON_BITS-1:0] button_bits_o,
  input logic                   packet_done_o,
  input logic                   byte_stored_o,
  input logic [COUNT_BITS-1:0]  packets_seen_o,
  input logic [COUNT_BITS-1:0]  bytes_seen_o
);

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ptr_x_o) &&
      $stable(ptr_y_o) && $stable(bytes_seen_o))
    else $error("stalled result word changed");

  // Every accepted word shows a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // A completed packet is always a stored byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_done_o |-> byte_stored_o)
    else $error("packet done without byte stored");

  // Reinitialize clears counters and buttons
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_REINIT) |=>
      packets_seen_o == '0 && bytes_seen_o == '0 && button_bits_o == '0 &&
      !packet_done_o && !byte_stored_o)
    else $error("reinitialize did not clear state");

  // A byte from the keyboard port leaves cursor and counters unchanged and clears both flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_BYTE) && !from_aux_i |=>
      !packet_done_o && !byte_stored_o && $stable(bytes_seen_o) &&
      $stable(packets_seen_o) && $stable(ptr_x_o) && $stable(ptr_y_o))
    else $error("non-aux byte changed state");

endmodule

bind ps2_mouse_packet_cursor_unit ps2mc_checker #(
  .COORD_BITS (COORD_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_ps2mc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .op_i           (op_i),
  .from_aux_i     (from_aux_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .ptr_x_o        (ptr_x_o),
  .ptr_y_o        (ptr_y_o),
  .button_bits_o  (button_bits_o),
  .packet_done_o  (packet_done_o),
  .byte_stored_o  (byte_stored_o),
  .packets_seen_o (packets_seen_o),
  .bytes_seen_o   (bytes_seen_o)
);

@@ sim/ps2_mouse_packet_cursor_unit_tb.sv @@
// Self-checking testbench for the PS/2 mouse packet cursor unit.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_unit_tb
  import ps2mc_pkg::*;
;

  localparam int unsigned XY_BITS     = 12;
  localparam int unsigned CNT_BITS    = 32;
  localparam int          XY_MAX      = (1 << XY_BITS) - 1;
  // Cycles without any handshake before the run is declared hung
  localparam int          STALL_LIMIT = 4000;
  localparam int          PHASE_WORDS = 172;
  localparam int          NUM_PHASES  = 6;

  // One result word as the block presents it
  typedef struct packed {
    logic [XY_BITS-1:0]     x;
    logic [XY_BITS-1:0]     y;
    logic [BUTTON_BITS-1:0] buttons;
    logic                   done;
    logic                   stored;
    logic [CNT_BITS-1:0]    packets;
    logic [CNT_BITS-1:0]    bytes;
  } cursor_word_t;

  // Cursor model plus the queue of result words still owed by the block
  class cursor_scoreboard;
    logic [SIZE_W-1:0]      scr_w;
    logic [SIZE_W-1:0]      scr_h;
    logic [7:0]             pkt_hold [2];
    logic [IDX_W-1:0]       pkt_idx;
    logic [XY_BITS-1:0]     cur_x;
    logic [XY_BITS-1:0]     cur_y;
    logic [BUTTON_BITS-1:0] btn;
    logic [CNT_BITS-1:0]    pkt_count;
    logic [CNT_BITS-1:0]    aux_count;
    cursor_word_t           owed[$];
    int                     errors;

    function new();
      scr_w      = RESET_WIDTH;
      scr_h      = RESET_HEIGHT;
      pkt_hold   = '{8'h00, 8'h00};
      pkt_idx    = IDX_FIRST;
      cur_x      = XY_BITS'(RESET_WIDTH / 2);
      cur_y      = XY_BITS'(RESET_HEIGHT / 2);
      btn        = '0;
      pkt_count  = '0;
      aux_count  = '0;
      errors     = 0;
    endfunction

    function void set_size(cfg_idx_e idx, logic [SIZE_W-1:0] v);
      if (idx == REG_SCREEN_WIDTH) scr_w = v;
      else scr_h = v;
    endfunction

    // Highest coordinate on a screen of this size; zero acts as one
    function int edge_of(logic [SIZE_W-1:0] size);
      int m;
      m = (size == 0) ? 0 : int'(size) - 1;
      return (m > XY_MAX) ? XY_MAX : m;
    endfunction

    function int center_of(logic [SIZE_W-1:0] size);
      int c;
      c = int'(size) / 2;
      return (c > XY_MAX) ? XY_MAX : c;
    endfunction

    function logic [XY_BITS-1:0] clamp(int v, int hi);
      if (v < 0) return '0;
      if (v > hi) return XY_BITS'(hi);
      return XY_BITS'(v);
    endfunction

    // Advance the cursor state by one accepted word and owe its result
    function void note_word(op_e op, logic [7:0] b, logic aux);
      cursor_word_t w;
      int nx, ny;
      w.done   = 1'b0;
      w.stored = 1'b0;
      if (op == OP_REINIT) begin
        cur_x      = XY_BITS'(center_of(scr_w));
        cur_y      = XY_BITS'(center_of(scr_h));
        pkt_idx    = IDX_FIRST;
        btn        = '0;
        pkt_count  = '0;
        aux_count  = '0;
      end else if (aux) begin
        aux_count++;
        if (pkt_idx == IDX_FIRST && (b & FIRST_MASK) != FIRST_MATCH) begin
          // header out of sync: count it, drop it
        end else if (pkt_idx != IDX_THIRD) begin
          pkt_hold[pkt_idx] = b;
          pkt_idx++;
          w.stored = 1'b1;
        end else begin
          nx        = int'(cur_x) + int'($signed(pkt_hold[1]));
          ny        = int'(cur_y) - int'($signed(b));
          cur_x     = clamp(nx, edge_of(scr_w));
          cur_y     = clamp(ny, edge_of(scr_h));
          btn       = pkt_hold[0][BUTTON_BITS-1:0];
          pkt_count++;
          pkt_idx   = IDX_FIRST;
          w.stored  = 1'b1;
          w.done    = 1'b1;
        end
      end
      w.x       = cur_x;
      w.y       = cur_y;
      w.buttons = btn;
      w.packets = pkt_count;
      w.bytes   = aux_count;
      owed.push_back(w);
    endfunction

    function void compare(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_word(cursor_word_t got);
      cursor_word_t exp;
      if (owed.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none got x=%0d y=%0d",
                 $time, got.x, got.y);
        errors++;
        return;
      end
      exp = owed.pop_front();
      compare("ptr_x", exp.x, got.x);
      compare("ptr_y", exp.y, got.y);
      compare("button_bits", exp.buttons, got.buttons);
      compare("packet_done", exp.done, got.done);
      compare("byte_stored", exp.stored, got.stored);
      compare("packets_seen", exp.packets, got.packets);
      compare("bytes_seen", exp.bytes, got.bytes);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic                   cfg_idx_i   = REG_SCREEN_WIDTH;
  logic [SIZE_W-1:0]      cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic                   op_i        = OP_BYTE;
  logic [7:0]             data_byte_i = '0;
  logic                   from_aux_i  = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [XY_BITS-1:0]     ptr_x_o;
  logic [XY_BITS-1:0]     ptr_y_o;
  logic [BUTTON_BITS-1:0] button_bits_o;
  logic                   packet_done_o;
  logic                   byte_stored_o;
  logic [CNT_BITS-1:0]    packets_seen_o;
  logic [CNT_BITS-1:0]    bytes_seen_o;

  cursor_scoreboard sb = new();

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both, lightly
  int idle_mode     = 0;
  int counted_words = 0;
  int quiet_cycles  = 0;

  always #6 clk_i = ~clk_i;

  ps2_mouse_packet_cursor_unit #(
    .COORD_BITS(XY_BITS),
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .data_byte_i,
    .from_aux_i,
    .out_valid_o,
    .out_ready_i,
    .ptr_x_o,
    .ptr_y_o,
    .button_bits_o,
    .packet_done_o,
    .byte_stored_o,
    .packets_seen_o,
    .bytes_seen_o
  );

  cursor_word_t out_word;
  assign out_word = '{ptr_x_o, ptr_y_o, button_bits_o, packet_done_o,
                      byte_stored_o, packets_seen_o, bytes_seen_o};

  function automatic bit sender_rests();
    case (idle_mode)
      1: return $urandom_range(0, 99) < 86;
      3: return $urandom_range(0, 99) < 31;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      2: return $urandom_range(0, 99) < 86;
      3: return $urandom_range(0, 99) < 31;
      default: return 1'b0;
    endcase
  endfunction

  // Sample results on the edge, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_word);
    out_ready_i <= !receiver_stalls();
  end

  // Any handshake on either channel counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one word and hold it until taken; call on a rising edge.
  // Valid stays high across back-to-back words and drops only for a gap.
  task automatic send_word(op_e op, logic [7:0] b, logic aux);
    while (sender_rests()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    from_aux_i  <= aux;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, b, aux);
    counted_words++;
  endtask

  // Stray keyboard byte slipped in between mouse bytes now and then
  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) send_word(OP_BYTE, 8'($urandom), 1'b0);
  endtask

  task automatic send_packet(logic [7:0] head, logic [7:0] dx, logic [7:0] dy);
    maybe_noise();
    send_word(OP_BYTE, head, 1'b1);
    maybe_noise();
    send_word(OP_BYTE, dx, 1'b1);
    // Drop the last byte once in a while to break the framing
    if ($urandom_range(0, 29) == 0) return;
    maybe_noise();
    send_word(OP_BYTE, dy, 1'b1);
  endtask

  // Bias a delta toward one direction so the cursor reaches the screen edges
  function automatic logic [7:0] pick_delta(bit toward_plus);
    case ($urandom_range(0, 3))
      0, 1:    return toward_plus ? 8'h7F : 8'h80;
      2:       return toward_plus ? {1'b0, 7'($urandom)} : {1'b1, 7'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_random(int budget);
    int  target;
    int  roll;
    int  pkts;
    bit  drift_x;
    bit  drift_y;
    target  = counted_words + budget;
    pkts    = 0;
    drift_x = $urandom_range(0, 1);
    drift_y = $urandom_range(0, 1);
    while (counted_words < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_word(OP_REINIT, 8'($urandom), 1'($urandom));
      end else if (roll < 7) begin
        send_word(OP_BYTE, 8'($urandom), 1'b0);
      end else if (roll < 12) begin
        send_word(OP_BYTE, 8'($urandom), 1'b1);
      end else begin
        // Flip the drift every so often so both edges get hit
        if (pkts % 48 == 47) begin
          drift_x = $urandom_range(0, 1);
          drift_y = $urandom_range(0, 1);
        end
        send_packet((8'($urandom) & ~FIRST_MASK) | FIRST_MATCH,
                    pick_delta(drift_x), pick_delta(drift_y));
        pkts++;
      end
    end
  endtask

  // Drain the block, then write both screen registers back to back
  task automatic apply_screen(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SCREEN_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    sb.set_size(REG_SCREEN_WIDTH, w);
    cfg_idx_i  <= REG_SCREEN_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    sb.set_size(REG_SCREEN_HEIGHT, h);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0] widths  [NUM_PHASES];
    logic [SIZE_W-1:0] heights [NUM_PHASES];
    // Phase 0 runs on the reset size; phase 2 shrinks the screen under the
    // cursor; zero and oversized values exercise both saturation ends.
    widths  = '{RESET_WIDTH, 13'd4096, 13'd1, 13'd0, 13'd8191, 13'd0};
    heights = '{RESET_HEIGHT, 13'd4096, 13'd1, 13'd8191, 13'd0, 13'd0};
    widths[5]  = SIZE_W'($urandom_range(2, 4095));
    heights[5] = SIZE_W'($urandom_range(2, 4095));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on the reset screen, no idling
    send_word(OP_REINIT, 8'hFF, 1'b1);          // payload ignored on reinit
    send_word(OP_BYTE, 8'h08, 1'b0);            // keyboard byte, ignored
    send_word(OP_BYTE, 8'h00, 1'b1);            // bad header: bit 3 low
    send_word(OP_BYTE, 8'hFF, 1'b1);            // bad header: bits 7, 6 high
    send_word(OP_BYTE, 8'h88, 1'b1);            // bad header: bit 7 high
    send_packet(8'h0F, 8'h7F, 8'h80);           // all buttons, largest moves
    send_word(OP_BYTE, 8'h08, 1'b1);            // header, then a stray byte
    send_word(OP_BYTE, 8'h55, 1'b0);
    send_word(OP_BYTE, 8'h80, 1'b1);
    send_word(OP_BYTE, 8'h7F, 1'b1);
    send_packet(8'h09, 8'h00, 8'h00);           // no movement
    send_packet(8'h3A, 8'hFF, 8'h01);           // header with spare bits set
    send_word(OP_REINIT, 8'h00, 1'b0);
    send_packet(8'h08, 8'h80, 8'h7F);
    send_packet(8'h0C, 8'h08, 8'hC8);           // header pattern as delta bytes

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) apply_screen(widths[ph], heights[ph]);
      idle_mode = ph % 4;
      // Recenter on the new screen, except when testing a shrink
      if (ph != 2) send_word(OP_REINIT, 8'($urandom), 1'($urandom));
      run_random(PHASE_WORDS);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ps2mc_pkg.sv
src/ps2mc_axis.sv
src/ps2_mouse_packet_cursor_unit.sv
src/ps2mc_checker.sv
sim/ps2_mouse_packet_cursor_unit_tb.sv
